/* hw/rtl/mtr_pkg.sv */
// Shared types, constants and saturating helpers for the media timestamp rebuilder.
// No dependencies; every other file imports this package.
package mtr_pkg;

  localparam int MAX_STREAMS = 64;
  localparam int IDX_W       = $clog2(MAX_STREAMS);
  localparam int TS_W        = 64;
  localparam int IN_TS_W     = 48;
  localparam int MULB_W      = 36;
  localparam int PROD_W      = 84;
  localparam int DEN_W       = 31;
  localparam int DUR_W       = 17;
  localparam int CNT_W       = 7;

  localparam logic [19:0]          US_PER_SEC  = 20'd1000000;
  localparam logic [DUR_W-1:0]     VIDEO_DUR   = 17'd40000;
  localparam logic [IN_TS_W-1:0]   AUDIO_NUMER = 48'd1024000000;
  localparam logic [18:0]          RATE_MIN    = 19'd11025;
  localparam logic [18:0]          RATE_MAX    = 19'd48000;
  localparam logic [TS_W-1:0]      GAP_LIMIT   = 64'd5;
  localparam logic [TS_W-1:0]      REANCHOR    = 64'd10;

  localparam logic signed [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic signed [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_BASE     = 2'd1,
    ST_BEFORE_BASE = 2'd2,
    ST_BACKWARD    = 2'd3
  } status_t;

  // per-stream entry
  typedef struct packed {
    logic signed [TS_W-1:0] lin;
    logic signed [TS_W-1:0] lout;
    logic signed [TS_W-1:0] gap;
  } entry_t;

  function automatic logic signed [TS_W-1:0] sat_add(input logic signed [TS_W-1:0] a,
                                                     input logic signed [TS_W-1:0] b);
    logic signed [TS_W:0] s;
    s = {a[TS_W-1], a} + {b[TS_W-1], b};
    if (s[TS_W] != s[TS_W-1]) sat_add = s[TS_W] ? TS_MIN : TS_MAX;
    else sat_add = s[TS_W-1:0];
  endfunction

  function automatic logic signed [TS_W-1:0] sat_sub(input logic signed [TS_W-1:0] a,
                                                     input logic signed [TS_W-1:0] b);
    logic signed [TS_W:0] s;
    s = {a[TS_W-1], a} - {b[TS_W-1], b};
    if (s[TS_W] != s[TS_W-1]) sat_sub = s[TS_W] ? TS_MIN : TS_MAX;
    else sat_sub = s[TS_W-1:0];
  endfunction

endpackage

/* hw/rtl/mtr_muldiv.sv */
// Shared shift-add multiplier followed by restoring divider, one bit per cycle.
// Depends on mtr_pkg.
module mtr_muldiv import mtr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [IN_TS_W-1:0]   a,
  input  logic [MULB_W-1:0]    b,
  input  logic [DEN_W-1:0]     den,
  input  logic                 rnd,
  output logic                 done,
  output logic [PROD_W-1:0]    q
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_MUL  = 3'b010,
    U_DIV  = 3'b100
  } ust_t;

  ust_t              st_r, st_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] ash_r, ash_nxt;
  logic [MULB_W-1:0] bsh_r, bsh_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W+1:0]  trial;
  logic              ge;

  // acc holds the product, then the dividend shifting out / quotient shifting in
  assign trial = {1'b0, rem_r, acc_r[PROD_W-1]} - {2'b0, den_r};
  assign ge    = !trial[DEN_W+1];

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    bsh_nxt  = bsh_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (st_r)
      U_IDLE: begin
        if (start) begin
          acc_nxt = rnd ? PROD_W'(den >> 1) : '0;
          ash_nxt = PROD_W'(a);
          bsh_nxt = b;
          den_nxt = den;
          cnt_nxt = '0;
          st_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        if (bsh_r[0]) acc_nxt = acc_r + ash_r;
        ash_nxt = {ash_r[PROD_W-2:0], 1'b0};
        bsh_nxt = bsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MULB_W - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = ge ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], acc_r[PROD_W-1]};
        acc_nxt = {acc_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    bsh_r <= bsh_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign q    = acc_r;

endmodule

/* hw/rtl/mtr_mem.sv */
// Per-stream state memory: one write port, a read port at the item's stream
// and a read port at the base stream. Depends on mtr_pkg.
module mtr_mem import mtr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_a,
  output entry_t           rd_b,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data
);

  entry_t                 mem [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] vld_r;
  entry_t                 a_r, b_r;
  logic                   va_r, vb_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) begin
      a_r <= mem[rd_idx];
      b_r <= mem[0];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_idx] <= 1'b1;
      if (rd_en) begin
        va_r <= vld_r[rd_idx];
        vb_r <= vld_r[0];
      end
    end
  end

  assign rd_a = va_r ? a_r : '0;
  assign rd_b = vb_r ? b_r : '0;

endmodule

/* hw/rtl/media_timestamp_rebuilder_top.sv */
// Top level of the media timestamp rebuilder: sequencer and timestamp datapath.
// Depends on mtr_pkg, mtr_muldiv and mtr_mem.
//
// One packet is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with out_valid high, and the receiver
// cannot hold it off; busy is low again in the cycle out_valid is high, so
// the next item may start then. The time an item takes is set by the shared
// multiply/divide unit, which multiplies and then divides per operation and
// runs twice per item (pts, dts), plus once more for the audio frame
// duration; the states S_C1 to S_C4 then finish the gap logic and the result.
// Per-stream state lives in a 64-entry memory read once at acceptance and
// written back at most once at the end of the item; after reset all entries
// read as zero with no clearing pass.
module media_timestamp_rebuilder_top import mtr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [IDX_W-1:0]          in_stream_index,
  input  logic signed [IN_TS_W-1:0] in_pts_in,
  input  logic signed [IN_TS_W-1:0] in_dts_in,
  input  logic [15:0]               in_timebase_num,
  input  logic [DEN_W-1:0]          in_timebase_den,
  input  logic                      in_is_audio,
  input  logic [18:0]               in_sample_rate,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic signed [TS_W-1:0]    out_pts_out,
  output logic signed [TS_W-1:0]    out_dts_out
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DUR  = 8'b0000_0010,
    S_PTS  = 8'b0000_0100,
    S_DTS  = 8'b0000_1000,
    S_C1   = 8'b0001_0000,
    S_C2   = 8'b0010_0000,
    S_C3   = 8'b0100_0000,
    S_C4   = 8'b1000_0000
  } st_t;

  st_t st_r, st_nxt;

  // item capture
  logic [IDX_W-1:0]          idx_r;
  logic signed [IN_TS_W-1:0] pts_r, dts_r;
  logic [MULB_W-1:0]         bnum_r;
  logic                      num0_r;
  logic [DEN_W-1:0]          den_r;
  logic [15:0]               rate_r;
  logic [DUR_W-1:0]          dur_r;
  logic                      base_r;
  logic                      go_r;

  // datapath registers
  logic signed [TS_W-1:0] pus_r, dus_r, step_r, diff_r, dist_r, odts_r, sum_r;
  logic                   before_r, gap_r;
  status_t                status_r;

  // output registers
  logic                   ovld_r;
  status_t                ostat_r;
  logic signed [TS_W-1:0] opts_r, odts_out_r;

  logic                   accept;
  logic [18:0]            rate_cl;
  logic [IN_TS_W-1:0]     u_a;
  logic [MULB_W-1:0]      u_b;
  logic [DEN_W-1:0]       u_den;
  logic                   u_rnd;
  logic                   u_done;
  logic [PROD_W-1:0]      u_q;
  logic signed [TS_W-1:0] conv;
  logic signed [IN_TS_W-1:0] cur_ts;
  entry_t                 ent_a, ent_b, wr_data;
  logic                   wr_en;
  logic [TS_W-1:0]        dur64;
  logic signed [TS_W-1:0] lim5, lim10, dur_s, distc, opts;
  logic                   gap_now;

  assign accept = start && !busy;
  assign busy   = (st_r != S_IDLE);

  assign rate_cl = (in_sample_rate < RATE_MIN) ? RATE_MIN :
                   (in_sample_rate > RATE_MAX) ? RATE_MAX : in_sample_rate;

  // operands of the shared unit follow the state
  assign cur_ts = (st_r == S_PTS) ? pts_r : dts_r;
  always_comb begin
    if (st_r == S_DUR) begin
      u_a   = AUDIO_NUMER;
      u_b   = MULB_W'(1);
      u_den = DEN_W'(rate_r);
      u_rnd = 1'b0;
    end else begin
      u_a   = cur_ts[IN_TS_W-1] ? (~cur_ts + 1'b1) : cur_ts;
      u_b   = bnum_r;
      u_den = (den_r == '0) ? DEN_W'(1) : den_r;
      u_rnd = 1'b1;
    end
  end

  mtr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (u_a),
    .b     (u_b),
    .den   (u_den),
    .rnd   (u_rnd),
    .done  (u_done),
    .q     (u_q)
  );

  // sign, saturation and zero-denominator handling of a rescaled timestamp
  always_comb begin
    if (den_r == '0) begin
      if (cur_ts == '0 || num0_r) conv = '0;
      else conv = cur_ts[IN_TS_W-1] ? TS_MIN : TS_MAX;
    end else if (u_q[PROD_W-1:TS_W-1] != '0) begin
      conv = cur_ts[IN_TS_W-1] ? TS_MIN : TS_MAX;
    end else begin
      conv = cur_ts[IN_TS_W-1] ? -$signed(u_q[TS_W-1:0]) : $signed(u_q[TS_W-1:0]);
    end
  end

  mtr_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (in_stream_index),
    .rd_a    (ent_a),
    .rd_b    (ent_b),
    .wr_en   (wr_en),
    .wr_idx  (idx_r),
    .wr_data (wr_data)
  );

  assign dur64   = TS_W'(dur_r);
  assign dur_s   = $signed(dur64);
  assign lim5    = $signed(dur64 * GAP_LIMIT);
  assign lim10   = $signed(dur64 * REANCHOR);
  assign gap_now = step_r[TS_W-1] || (step_r > lim5);
  assign distc   = (dist_r < dur_s) ? dur_s : (dist_r > lim10) ? lim10 : dist_r;
  assign opts    = sat_add(sum_r, $signed({dur64[TS_W-2:0], 1'b0}));

  // write back: gap start on a before-base or backward skip, full entry on success
  always_comb begin
    wr_data = ent_a;
    wr_en   = 1'b0;
    if (st_r == S_C4) begin
      if (status_r == ST_OK) begin
        wr_en        = 1'b1;
        wr_data.lin  = dus_r;
        wr_data.lout = odts_r;
        if (gap_r) wr_data.gap = dus_r;
      end else if (status_r == ST_BEFORE_BASE || status_r == ST_BACKWARD) begin
        wr_en       = 1'b1;
        wr_data.gap = dus_r;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (accept) st_nxt = in_is_audio ? S_DUR : S_PTS;
      S_DUR:   if (u_done) st_nxt = S_PTS;
      S_PTS:   if (u_done) st_nxt = S_DTS;
      S_DTS:   if (u_done) st_nxt = S_C1;
      S_C1:    st_nxt = S_C2;
      S_C2:    st_nxt = S_C3;
      S_C3:    st_nxt = S_C4;
      S_C4:    st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      go_r   <= 1'b0;
      base_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      go_r   <= (accept || (u_done && (st_r == S_DUR || st_r == S_PTS)));
      ovld_r <= (st_r == S_C4);
      if (st_r == S_C4 && idx_r == '0) base_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_stream_index;
      pts_r  <= in_pts_in;
      dts_r  <= in_dts_in;
      bnum_r <= MULB_W'(in_timebase_num) * MULB_W'(US_PER_SEC);
      num0_r <= (in_timebase_num == '0);
      den_r  <= in_timebase_den;
      rate_r <= rate_cl[15:0];
      dur_r  <= VIDEO_DUR;
    end
    if (st_r == S_DUR && u_done) dur_r <= u_q[DUR_W-1:0];
    if (st_r == S_PTS && u_done) pus_r <= conv;
    if (st_r == S_DTS && u_done) dus_r <= conv;
    if (st_r == S_C1) begin
      step_r   <= sat_sub(dus_r, ent_a.lin);
      diff_r   <= sat_sub(pus_r, dus_r);
      dist_r   <= sat_sub(dus_r, ent_b.gap);
      before_r <= (dus_r < ent_b.gap);
    end
    if (st_r == S_C2) begin
      gap_r <= gap_now;
      if (gap_now && idx_r == '0) odts_r <= sat_add(ent_a.lout, dur_s);
      else if (gap_now)           odts_r <= sat_add(ent_b.lout, distc);
      else                        odts_r <= sat_add(ent_a.lout, step_r);
    end
    if (st_r == S_C3) begin
      sum_r <= sat_add(odts_r, diff_r);
      if (idx_r != '0 && !base_r)                status_r <= ST_NO_BASE;
      else if (idx_r != '0 && gap_r && before_r) status_r <= ST_BEFORE_BASE;
      else if (idx_r != '0 && gap_r && odts_r < ent_a.lout)
                                                 status_r <= ST_BACKWARD;
      else                                       status_r <= ST_OK;
    end
    if (st_r == S_C4) begin
      ostat_r    <= status_r;
      opts_r     <= (status_r == ST_OK) ? opts : '0;
      odts_out_r <= (status_r == ST_OK) ? odts_r : '0;
    end
  end

  assign out_valid   = ovld_r;
  assign out_status  = ostat_r;
  assign out_pts_out = opts_r;
  assign out_dts_out = odts_out_r;

endmodule

/* hw/rtl/mtr_chk.sv */
// Port-level checker for the media timestamp rebuilder, bound to the top level.
// Depends on mtr_pkg.
module mtr_chk import mtr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [1:0]             out_status,
  input logic signed [TS_W-1:0] out_pts_out,
  input logic signed [TS_W-1:0] out_dts_out
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after item accept");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held more than one cycle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without an item in flight");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pts_out == '0 && out_dts_out == '0)
    else $error("skipped item carries timestamps");

endmodule

bind media_timestamp_rebuilder_top mtr_chk u_chk (.*);

/* sim/mtr_checker.sv */
// Checker for the media timestamp rebuilder: watches the item and result channels,
// predicts each result from its own copy of the per-stream state, compares fields.
// Depends on mtr_pkg.
`timescale 1ns / 1ps

module mtr_checker import mtr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [IDX_W-1:0]          in_stream_index,
  input  logic signed [IN_TS_W-1:0] in_pts_in,
  input  logic signed [IN_TS_W-1:0] in_dts_in,
  input  logic [15:0]               in_timebase_num,
  input  logic [DEN_W-1:0]          in_timebase_den,
  input  logic                      in_is_audio,
  input  logic [18:0]               in_sample_rate,
  input  logic                      out_valid,
  input  logic [1:0]                out_status,
  input  logic signed [TS_W-1:0]    out_pts_out,
  input  logic signed [TS_W-1:0]    out_dts_out,
  output int                        n_pending,
  output int                        n_fail
);

  typedef struct {
    status_t                status;
    logic signed [TS_W-1:0] pts;
    logic signed [TS_W-1:0] dts;
  } rebuilt_t;

  rebuilt_t               rebuilt_q[$];
  logic                   base_seen;
  logic signed [TS_W-1:0] prev_in_dts[MAX_STREAMS];
  logic signed [TS_W-1:0] prev_out_dts[MAX_STREAMS];
  logic signed [TS_W-1:0] gap_at[MAX_STREAMS];
  int                     fails;

  function automatic logic signed [TS_W-1:0] add_sat(logic signed [TS_W-1:0] a,
                                                     logic signed [TS_W-1:0] b);
    logic signed [TS_W:0] s;
    s = $signed({a[TS_W-1], a}) + $signed({b[TS_W-1], b});
    if (s > $signed({TS_MAX[TS_W-1], TS_MAX})) return TS_MAX;
    if (s < $signed({TS_MIN[TS_W-1], TS_MIN})) return TS_MIN;
    return s[TS_W-1:0];
  endfunction

  function automatic logic signed [TS_W-1:0] sub_sat(logic signed [TS_W-1:0] a,
                                                     logic signed [TS_W-1:0] b);
    logic signed [TS_W:0] s;
    s = $signed({a[TS_W-1], a}) - $signed({b[TS_W-1], b});
    if (s > $signed({TS_MAX[TS_W-1], TS_MAX})) return TS_MAX;
    if (s < $signed({TS_MIN[TS_W-1], TS_MIN})) return TS_MIN;
    return s[TS_W-1:0];
  endfunction

  // ticks * num * 1e6 / den, nearest with halves away from zero, saturated
  function automatic logic signed [TS_W-1:0] ticks_to_us(logic signed [IN_TS_W-1:0] v,
                                                         logic [15:0] num,
                                                         logic [DEN_W-1:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic         neg;
    neg = v < 0;
    if (v == 0 || num == 0) return '0;
    if (den == 0) return neg ? TS_MIN : TS_MAX;
    mag = neg ? 128'(-64'(v)) : 128'(v);
    q = (mag * 128'(num) * 128'd1000000 + 128'(den / 2)) / 128'(den);
    if (q > 128'(TS_MAX)) return neg ? TS_MIN : TS_MAX;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic rebuilt_t rebuild_timestamps();
    rebuilt_t               r;
    int unsigned            rate;
    logic signed [TS_W-1:0] dur, p, d, step, odts, span;
    int                     i;
    r.status = ST_OK;
    r.pts    = '0;
    r.dts    = '0;
    i        = in_stream_index;
    if (in_is_audio) begin
      rate = in_sample_rate;
      if (rate < 11025) rate = 11025;
      if (rate > 48000) rate = 48000;
      dur = 64'd1024000000 / rate;
    end else begin
      dur = 64'd40000;
    end
    p    = ticks_to_us(in_pts_in, in_timebase_num, in_timebase_den);
    d    = ticks_to_us(in_dts_in, in_timebase_num, in_timebase_den);
    step = sub_sat(d, prev_in_dts[i]);
    if (i == 0) begin
      if (step < 0 || step > 5 * dur) begin
        gap_at[0] = d;
        odts = add_sat(prev_out_dts[0], dur);
      end else begin
        odts = add_sat(prev_out_dts[0], step);
      end
      base_seen = 1'b1;
    end else begin
      if (!base_seen) begin
        r.status = ST_NO_BASE;
        return r;
      end
      if (step < 0 || step > 5 * dur) begin
        gap_at[i] = d;
        if (d < gap_at[0]) begin
          r.status = ST_BEFORE_BASE;
          return r;
        end
        // re-anchor to the base stream, distance clamped to 1..10 durations
        span = sub_sat(d, gap_at[0]);
        if (span < dur) span = dur;
        if (span > 10 * dur) span = 10 * dur;
        odts = add_sat(prev_out_dts[0], span);
        if (odts < prev_out_dts[i]) begin
          r.status = ST_BACKWARD;
          return r;
        end
      end else begin
        odts = add_sat(prev_out_dts[i], step);
      end
    end
    r.pts           = add_sat(add_sat(odts, sub_sat(p, d)), 2 * dur);
    r.dts           = odts;
    prev_in_dts[i]  = d;
    prev_out_dts[i] = odts;
    return r;
  endfunction

  always @(posedge clk) begin
    rebuilt_t e;
    if (!rst_n) begin
      rebuilt_q.delete();
      base_seen = 1'b0;
      for (int k = 0; k < MAX_STREAMS; k++) begin
        prev_in_dts[k]  = '0;
        prev_out_dts[k] = '0;
        gap_at[k]       = '0;
      end
      fails = 0;
    end else begin
      if (out_valid) begin
        if (rebuilt_q.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          e = rebuilt_q.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            fails++;
          end
          if (out_pts_out !== e.pts) begin
            $error("pts_out: expected %0d, got %0d", e.pts, out_pts_out);
            fails++;
          end
          if (out_dts_out !== e.dts) begin
            $error("dts_out: expected %0d, got %0d", e.dts, out_dts_out);
            fails++;
          end
        end
      end
      if (start && !busy) rebuilt_q.push_back(rebuild_timestamps());
    end
    n_pending <= rebuilt_q.size();
    n_fail    <= fails;
  end

endmodule

/* sim/testbench.sv */
// Top of the media timestamp rebuilder testbench: clock, reset, packet stimulus
// and the verdict. Depends on mtr_pkg, mtr_checker and media_timestamp_rebuilder_top.
`timescale 1ns / 1ps

module testbench;
  import mtr_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [IDX_W-1:0]          in_stream_index;
  logic signed [IN_TS_W-1:0] in_pts_in;
  logic signed [IN_TS_W-1:0] in_dts_in;
  logic [15:0]               in_timebase_num;
  logic [DEN_W-1:0]          in_timebase_den;
  logic                      in_is_audio;
  logic [18:0]               in_sample_rate;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic signed [TS_W-1:0]    out_pts_out;
  logic signed [TS_W-1:0]    out_dts_out;
  int                        n_pending;
  int                        n_fail;

  // stall watchdog: cycles with neither an accepted item nor a result
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM    = 480;
  localparam logic signed [IN_TS_W-1:0] TICK_MAX = {1'b0, {(IN_TS_W-1){1'b1}}};
  localparam logic signed [IN_TS_W-1:0] TICK_MIN = {1'b1, {(IN_TS_W-1){1'b0}}};

  media_timestamp_rebuilder_top dut (.*);

  mtr_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  int  stall_cycles;
  bit  run_live;

  always @(posedge clk) begin
    if (!run_live || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // per-stream tick position of the well-formed random streams
  longint tick_pos[MAX_STREAMS];
  bit     idle_on;

  // present one item, hold it until accepted, then maybe idle a while
  task automatic send_item(input logic [IDX_W-1:0] idx, input logic signed [IN_TS_W-1:0] pts,
                           input logic signed [IN_TS_W-1:0] dts, input logic [15:0] num,
                           input logic [DEN_W-1:0] den, input logic aud,
                           input logic [18:0] rate);
    int idle;
    in_stream_index <= idx;
    in_pts_in       <= pts;
    in_dts_in       <= dts;
    in_timebase_num <= num;
    in_timebase_den <= den;
    in_is_audio     <= aud;
    in_sample_rate  <= rate;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    idle = (idle_on && $urandom_range(0, 99) < 35) ? $urandom_range(1, 6) : 0;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  function automatic logic signed [IN_TS_W-1:0] any_ticks();
    return IN_TS_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [IDX_W-1:0]          s;
    logic signed [IN_TS_W-1:0] d;
    longint                    inc;
    int                        pick;
    run_live        = 1'b0;
    idle_on         = 1'b1;
    stall_cycles    = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_stream_index <= '0;
    in_pts_in       <= '0;
    in_dts_in       <= '0;
    in_timebase_num <= 16'd1;
    in_timebase_den <= 31'd1;
    in_is_audio     <= 1'b0;
    in_sample_rate  <= '0;
    for (int k = 0; k < MAX_STREAMS; k++) tick_pos[k] = 0;
    repeat (11) @(posedge clk);
    rst_n    <= 1'b1;
    run_live = 1'b1;
    @(posedge clk);

    // directed: 90 kHz video unless noted
    send_item(6'd1, 48'd0, 48'd0, 16'd1, 31'd90000, 1'b0, 19'd0);       // base not started
    send_item(6'd0, 48'd7200, 48'd0, 16'd1, 31'd90000, 1'b0, 19'd0);    // base starts
    send_item(6'd0, 48'd10800, 48'd3600, 16'd1, 31'd90000, 1'b0, 19'd0);
    send_item(6'd0, 48'd1000000, 48'd1000000, 16'd1, 31'd90000, 1'b0, 19'd0); // base gap
    send_item(6'd1, 48'd90000, 48'd90000, 16'd1, 31'd90000, 1'b0, 19'd0); // before base gap
    send_item(6'd1, 48'd1100000, 48'd1100000, 16'd1, 31'd90000, 1'b0, 19'd0); // re-anchor
    send_item(6'd1, 48'd1103600, 48'd1103600, 16'd1, 31'd90000, 1'b0, 19'd0);
    // stream 3 runs far ahead of the base, then gaps: time goes backward
    for (int k = 1; k <= 5; k++)
      send_item(6'd3, 48'(k * 16200), 48'(k * 16200), 16'd1, 31'd90000, 1'b0, 19'd0);
    send_item(6'd3, 48'd5000000, 48'd5000000, 16'd1, 31'd90000, 1'b0, 19'd0);
    // audio durations: rate below, at and above the clamp range
    send_item(6'd2, 48'd2000000, 48'd2000000, 16'd1, 31'd48000, 1'b1, 19'd0);
    send_item(6'd2, 48'd2001024, 48'd2001024, 16'd1, 31'd48000, 1'b1, 19'd11025);
    send_item(6'd2, 48'd2002048, 48'd2002048, 16'd1, 31'd48000, 1'b1, 19'd48000);
    send_item(6'd2, 48'd2003072, 48'd2003072, 16'd1, 31'd48000, 1'b1, 19'd384000);
    // extremes: saturating rescale and saturating sums
    send_item(6'd0, TICK_MAX, TICK_MIN, 16'd65535, 31'd1, 1'b0, 19'd0);
    send_item(6'd0, TICK_MIN, TICK_MAX, 16'd65535, 31'd1, 1'b1, 19'd262143);
    send_item(6'd63, TICK_MAX, TICK_MAX, 16'd1, 31'h7FFFFFFF, 1'b0, 19'd0);
    send_item(6'd63, -48'sd3, -48'sd3, 16'd1, 31'd2, 1'b0, 19'd0);       // negative timestamp
    send_item(6'd5, 48'd5, 48'd5, 16'd1, 31'd2, 1'b0, 19'd0);

    // random: mostly well-formed streams, some gaps and noise
    for (int n = 0; n < N_RANDOM; n++) begin
      idle_on = !(n >= 150 && n < 250);
      // hold off until everything in flight has come back
      if (n == 300) begin
        start <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
      end
      pick = $urandom_range(0, 99);
      s    = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
      if (pick < 15) begin
        send_item(6'($urandom()), any_ticks(), any_ticks(), 16'($urandom_range(1, 65535)),
                  31'($urandom_range(1, 32'h7FFFFFFF)), 1'($urandom()),
                  19'($urandom_range(0, 384000)));
      end else begin
        if (s[0]) inc = 1024 + $signed($urandom_range(0, 64)) - 32;
        else inc = 3600 + $signed($urandom_range(0, 200)) - 100;
        if (pick < 25) inc = $signed($urandom_range(0, 4000000)) - 1000000;
        tick_pos[s] = tick_pos[s] + inc;
        d = 48'(tick_pos[s]);
        send_item(s, d + 48'($urandom_range(0, 7200)), d, 16'd1,
                  s[0] ? 31'd48000 : 31'd90000, s[0], s[0] ? 19'd48000 : 19'd0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (400) @(posedge clk);
    if (n_fail == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* media_timestamp_rebuilder_top.f */
hw/rtl/mtr_pkg.sv
hw/rtl/mtr_muldiv.sv
hw/rtl/mtr_mem.sv
hw/rtl/media_timestamp_rebuilder_top.sv
hw/rtl/mtr_chk.sv
sim/mtr_checker.sv
sim/testbench.sv
